// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL; empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Expression must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: expression not true");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication not met");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/sfd_pkg.sv -----
// Package for the S.BUS frame decoder: constants, register codes and shared types.
package sfd_pkg;

  localparam int NUM_CHANNELS   = 16;
  localparam int FRAME_LENGTH   = 25;
  localparam int FLAGS_POSITION = 23;
  localparam int STORE_DEPTH    = 24;
  localparam int DATA_BYTES     = 22;
  localparam int DATA_W         = DATA_BYTES * 8;
  localparam int CHAN_BITS      = 11;
  localparam int CHAN_IDX_W     = 4;
  localparam int POS_W          = 5;
  localparam int GAIN_W         = 17;
  localparam int PROD_W         = CHAN_BITS + GAIN_W;
  localparam int FRAC_BITS      = 16;
  localparam int VALUE_W        = 16;
  localparam int DROPS_W        = 16;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = GAIN_W;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DATA_W     = 40;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  localparam logic [7:0]         RST_START_MARKER = 8'h0f;
  localparam logic [GAIN_W-1:0]  RST_SCALE_GAIN   = 17'd39985;
  localparam logic [VALUE_W-1:0] RST_SCALE_OFFSET = 16'd895;
  localparam logic [2:0]         RST_FAILSAFE_BIT = 3'd3;
  localparam logic [2:0]         RST_LOST_BIT     = 3'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_MARKER = 3'd0,
    REG_SCALE_GAIN   = 3'd1,
    REG_SCALE_OFFSET = 3'd2,
    REG_FAILSAFE_BIT = 3'd3,
    REG_LOST_BIT     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]         start_marker;
    logic [GAIN_W-1:0]  scale_gain;
    logic [VALUE_W-1:0] scale_offset;
    logic [2:0]         failsafe_bit;
    logic [2:0]         lost_bit;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic               failsafe;
    logic               lost;
    logic [DROPS_W-1:0] drops;
  } job_t;

  typedef struct packed {
    logic [CHAN_IDX_W-1:0] channel_index;
    logic [VALUE_W-1:0]    channel_value;
    logic                  failsafe_flag;
    logic                  lost_flag;
    logic [DROPS_W-1:0]    drops_seen;
    logic                  final_of_frame;
  } result_t;

endpackage

// ----- rtl/core/sfd_front.sv -----
// Front end: collects frame bytes, checks the start marker, counts drops, queues good frames.
module sfd_front (
  input  logic          clk,
  input  logic          rst,
  input  sfd_pkg::cfg_t cfg,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic          q_full,
  output logic          q_push,
  output sfd_pkg::job_t q_job
);
  import sfd_pkg::*;

  logic [7:0]         store [STORE_DEPTH];
  logic [POS_W-1:0]   pos;
  logic [DROPS_W-1:0] drops;
  logic               at_end;
  logic               good;
  logic               accept;
  logic [7:0]         flags;

  assign at_end   = pos >= POS_W'(FRAME_LENGTH - 1);
  assign good     = store[0] == cfg.start_marker;
  assign s_tready = !(at_end && good && q_full);
  assign accept   = s_tvalid && s_tready;
  assign q_push   = accept && at_end && good;
  assign flags    = store[FLAGS_POSITION];

  always_comb begin
    for (int i = 0; i < DATA_BYTES; i++) begin
      q_job.data[8*i +: 8] = store[i+1];
    end
    q_job.failsafe = flags[cfg.failsafe_bit];
    q_job.lost     = flags[cfg.failsafe_bit] | flags[cfg.lost_bit];
    q_job.drops    = drops;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      drops <= '0;
    end else if (accept) begin
      if (at_end) begin
        pos <= '0;
        if (!good && drops != '1) begin
          drops <= drops + DROPS_W'(1);
        end
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !at_end) begin
      store[pos] <= s_tdata;
    end
  end

endmodule

// ----- rtl/core/sfd_queue.sv -----
// Short frame-job queue between the front end and the channel engine.
module sfd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output sfd_pkg::job_t pop_job,
  output logic          empty
);
  import sfd_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- rtl/core/sfd_back.sv -----
// Channel engine: unpacks 11-bit channels, scales with rounding, adds offset, drives results.
module sfd_back (
  input  logic             clk,
  input  logic             rst,
  input  sfd_pkg::cfg_t    cfg,
  input  logic             q_empty,
  input  sfd_pkg::job_t    q_job,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output sfd_pkg::result_t res
);
  import sfd_pkg::*;

  logic                  active;
  logic [CHAN_IDX_W-1:0] chan;
  logic [DATA_W-1:0]     bits;
  logic                  job_fs;
  logic                  job_lost;
  logic [DROPS_W-1:0]    job_drops;
  logic                  last_ch;
  logic                  issue;
  logic                  load;

  logic                  p_valid;
  logic                  p_ready;
  logic [PROD_W-1:0]     p_prod;
  logic [CHAN_IDX_W-1:0] p_chan;
  logic                  p_last;
  logic                  p_fs;
  logic                  p_lost;
  logic [DROPS_W-1:0]    p_drops;

  logic                  out_adv;
  logic [PROD_W-1:0]     rounded;

  assign last_ch = chan == CHAN_IDX_W'(NUM_CHANNELS - 1);
  assign out_adv = !m_tvalid || m_tready;
  assign p_ready = !p_valid || out_adv;
  assign issue   = active && p_ready;
  assign load    = (!active || (issue && last_ch)) && !q_empty;
  assign q_pop   = load;
  assign rounded = p_prod + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      chan   <= '0;
    end else if (load) begin
      active <= 1'b1;
      chan   <= '0;
    end else if (issue) begin
      chan <= chan + CHAN_IDX_W'(1);
      if (last_ch) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bits      <= q_job.data;
      job_fs    <= q_job.failsafe;
      job_lost  <= q_job.lost;
      job_drops <= q_job.drops;
    end else if (issue) begin
      bits <= bits >> CHAN_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_prod  <= PROD_W'(bits[CHAN_BITS-1:0]) * PROD_W'(cfg.scale_gain);
      p_chan  <= chan;
      p_last  <= last_ch;
      p_fs    <= job_fs;
      p_lost  <= job_lost;
      p_drops <= job_drops;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && p_valid) begin
      res.channel_index  <= p_chan;
      res.channel_value  <= VALUE_W'(rounded[PROD_W-1:FRAC_BITS]) + cfg.scale_offset;
      res.failsafe_flag  <= p_fs;
      res.lost_flag      <= p_lost;
      res.drops_seen     <= p_drops;
      res.final_of_frame <= p_last;
    end
  end

endmodule

// ----- rtl/core/sbus_frame_decoder.sv -----
// Top level of the S.BUS frame decoder: configuration registers, front end, queue, channel engine.
//
//  port group        | dir  | payload
//  s_tvalid/tready   | in   | s_tdata[7:0] = rx_byte
//  m_tvalid/tready   | out  | m_tdata: channel_index, channel_value, failsafe_flag, lost_flag,
//                    |      |   drops_seen; m_tlast = final_of_frame
//  cfg_we            | in   | cfg_index selects register, cfg_data carries the value
//
// One byte is taken per cycle. The end byte of a good frame waits only while the
// two-entry frame queue is full. The channel engine gives one result per cycle while
// m_tready is high, 16 per frame, via the queue, load, multiply and output registers.
// Output stalls back up through the multiply stage into the queue, then the front end.
// Reset restores the register defaults and clears position, drop count and queue;
// the frame store holds no reset value and needs no clearing pass.
`include "assert_macros.svh"

module sbus_frame_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // [7:0] rx_byte
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [3:0] channel_index, [19:4] channel_value, [20] failsafe_flag, [21] lost_flag,
  // [37:22] drops_seen, [39:38] zero
  output logic [sfd_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                               m_tlast
);
  import sfd_pkg::*;

  cfg_t    cfg;
  job_t    push_job;
  job_t    pop_job;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= RST_START_MARKER;
      cfg.scale_gain   <= RST_SCALE_GAIN;
      cfg.scale_offset <= RST_SCALE_OFFSET;
      cfg.failsafe_bit <= RST_FAILSAFE_BIT;
      cfg.lost_bit     <= RST_LOST_BIT;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_START_MARKER: cfg.start_marker <= cfg_data[7:0];
        REG_SCALE_GAIN:   cfg.scale_gain   <= cfg_data[GAIN_W-1:0];
        REG_SCALE_OFFSET: cfg.scale_offset <= cfg_data[VALUE_W-1:0];
        REG_FAILSAFE_BIT: cfg.failsafe_bit <= cfg_data[2:0];
        REG_LOST_BIT:     cfg.lost_bit     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  sfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  sfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  sfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_job    (pop_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  assign m_tdata = {2'b00, res.drops_seen, res.lost_flag, res.failsafe_flag,
                    res.channel_value, res.channel_index};
  assign m_tlast = res.final_of_frame;

  `ASSERT_IMPLIES(a_no_push_when_full, clk, rst, q_push, !q_full)
  `ASSERT_IMPLIES(a_no_pop_when_empty, clk, rst, q_pop, !q_empty)
  `ASSERT_IMPLIES(a_last_is_top_channel, clk, rst, m_tvalid && m_tlast, m_tdata[3:0] == CHAN_IDX_W'(NUM_CHANNELS - 1))
  `ASSERT_IMPLIES(a_failsafe_sets_lost, clk, rst, m_tvalid && m_tdata[20], m_tdata[21])

endmodule
